// ----- design/sfc_pkg.sv -----
// Shared types, widths and codes for the segment frustum clipper.
// Depends on nothing; every other file of the block uses it.
package sfc_pkg;

   // Coordinate and datapath widths
   localparam int COORD_W  = 32;
   localparam int DIST_W   = COORD_W + 19;
   localparam int TOT_W    = DIST_W + 1;
   localparam int MAG_W    = COORD_W + 1;
   localparam int NUM_W    = TOT_W + MAG_W;
   localparam int CNT_W    = $clog2(MAG_W);
   localparam int PLANE_N  = 6;
   localparam int PLANE_W  = 3;
   localparam int AXIS_N   = 3;
   localparam int AXIS_W   = 2;

   // Configuration registers
   localparam int NEAR_W      = 31;
   localparam int ASPECT_W    = 17;
   localparam int CSR_DATA_W  = 31;
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEAR   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAR    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ASPECT = 2'd2;
   localparam logic [NEAR_W-1:0]   NEAR_RESET   = 31'd256;
   localparam logic [NEAR_W-1:0]   FAR_RESET    = 31'd1048576;
   localparam logic [ASPECT_W-1:0] ASPECT_RESET = 17'd49152;

   localparam int QUEUE_DEPTH = 4;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef enum logic [1:0] {
      CLIP_REJECT  = 2'd0,
      CLIP_ACCEPT  = 2'd1,
      CLIP_CLIPPED = 2'd2
   } status_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type start_z;
      coord_type end_x;
      coord_type end_y;
      coord_type end_z;
   } req_type;

   typedef struct packed {
      status_type clip_status;
      coord_type  out_start_x;
      coord_type  out_start_y;
      coord_type  out_start_z;
      coord_type  out_end_x;
      coord_type  out_end_y;
      coord_type  out_end_z;
   } rsp_type;

   typedef struct packed {
      logic [NEAR_W-1:0]   near;
      logic [NEAR_W-1:0]   far;
      logic [ASPECT_W-1:0] aspect;
   } cfg_type;

   typedef struct packed {
      req_type seg;
      logic    all_in;
   } entry_type;

   typedef logic [PLANE_N-1:0][DIST_W-1:0] dist_vec_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIST,
      BK_SETUP,
      BK_MUL,
      BK_DIV,
      BK_FIX,
      BK_DONE
   } back_state_type;

endpackage

// ----- design/segment_frustum_clipper.sv -----
// A segment inside all planes goes through the front hold register, the queue and
// the response register; others are tested plane by plane, and each plane that clips
// runs a shift-add multiply and a restoring divide per axis, one bit per cycle each.
// Throughput: one inside segment per cycle unless stalled; else the back end sets it.
// Reset: synchronous, clears queue and control; config regs return to 1.0, 4096.0, 0.75.
// Depends on sfc_pkg, sfc_front, sfc_fifo, sfc_back.
module segment_frustum_clipper #(
   parameter int QUEUE_DEPTH = sfc_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  sfc_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output sfc_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [sfc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sfc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   sfc_pkg::cfg_type   cfg_ff, cfg_in;
   logic               push_valid, push_ready, pop_valid, pop_ready;
   sfc_pkg::entry_type push_data, pop_data;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            sfc_pkg::CSR_NEAR:   cfg_in.near   = csr_wdata;
            sfc_pkg::CSR_FAR:    cfg_in.far    = csr_wdata;
            sfc_pkg::CSR_ASPECT: cfg_in.aspect = csr_wdata[sfc_pkg::ASPECT_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near   <= sfc_pkg::NEAR_RESET;
         cfg_ff.far    <= sfc_pkg::FAR_RESET;
         cfg_ff.aspect <= sfc_pkg::ASPECT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sfc_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .cfg(cfg_ff),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
   );

   sfc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
   );

   sfc_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

endmodule

// ----- design/sfc_dist.sv -----
// Signed distances of one point to all six clip planes.
// Depends on sfc_pkg.
module sfc_dist (
   input  sfc_pkg::coord_type    x,
   input  sfc_pkg::coord_type    y,
   input  sfc_pkg::coord_type    z,
   input  sfc_pkg::cfg_type      cfg,
   output sfc_pkg::dist_vec_type dist_out
);

   logic signed [sfc_pkg::DIST_W-1:0] xs, ys, zs, zsh, near_s, far_s, ax_s;
   logic signed [sfc_pkg::COORD_W+sfc_pkg::ASPECT_W:0] ax;

   // Widen inputs to distance width
   assign xs     = sfc_pkg::DIST_W'(x);
   assign ys     = sfc_pkg::DIST_W'(y);
   assign zs     = sfc_pkg::DIST_W'(z);
   assign zsh    = zs <<< 16;
   assign near_s = $signed(sfc_pkg::DIST_W'(cfg.near));
   assign far_s  = $signed(sfc_pkg::DIST_W'(cfg.far));

   // Aspect times forward coordinate, exact
   assign ax   = $signed({1'b0, cfg.aspect}) * x;
   assign ax_s = sfc_pkg::DIST_W'(ax);

   // Near, far, left, top, right, bottom
   assign dist_out[0] = near_s - xs;
   assign dist_out[1] = xs - far_s;
   assign dist_out[2] = -xs - ys;
   assign dist_out[3] = zsh - ax_s;
   assign dist_out[4] = ys - xs;
   assign dist_out[5] = -zsh - ax_s;

endmodule

// ----- design/sfc_front.sv -----
// Front end: takes request beats, flags segments inside all planes.
// Depends on sfc_pkg and sfc_dist.
module sfc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sfc_pkg::req_type    req_data,
   input  sfc_pkg::cfg_type    cfg,
   output logic                push_valid,
   input  logic                push_ready,
   output sfc_pkg::entry_type  push_data
);

   sfc_pkg::dist_vec_type dist_s, dist_e;
   logic                  any_out;
   logic                  hold_valid_ff, hold_valid_in;
   sfc_pkg::entry_type    hold_ff, hold_in;

   sfc_dist u_dist_start (
      .x(req_data.start_x), .y(req_data.start_y), .z(req_data.start_z),
      .cfg(cfg), .dist_out(dist_s)
   );

   sfc_dist u_dist_end (
      .x(req_data.end_x), .y(req_data.end_y), .z(req_data.end_z),
      .cfg(cfg), .dist_out(dist_e)
   );

   // Flag any end outside any plane
   always_comb begin
      any_out = 1'b0;
      for (int i = 0; i < sfc_pkg::PLANE_N; i++) begin
         if ($signed(dist_s[i]) > 0 || $signed(dist_e[i]) > 0) begin
            any_out = 1'b1;
         end
      end
   end

   assign req_ready  = !hold_valid_ff || push_ready;
   assign push_valid = hold_valid_ff;
   assign push_data  = hold_ff;

   // Load a new beat or drain the held one
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (push_ready) begin
         hold_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         hold_valid_in  = 1'b1;
         hold_in.seg    = req_data;
         hold_in.all_in = !any_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

endmodule

// ----- design/sfc_fifo.sv -----
// Short queue between front and back end.
// Depends on sfc_pkg.
module sfc_fifo #(
   parameter int DEPTH = sfc_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  sfc_pkg::entry_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output sfc_pkg::entry_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sfc_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- design/sfc_back.sv -----
// Back end: walks the six planes, interpolates with a shift-add multiplier
// and a restoring divider, and holds the response register. Depends on sfc_pkg, sfc_dist.
module sfc_back (
   input  logic               clock,
   input  logic               reset,
   input  sfc_pkg::cfg_type   cfg,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  sfc_pkg::entry_type pop_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sfc_pkg::rsp_type   rsp_data
);

   localparam int W  = sfc_pkg::COORD_W;
   localparam int DW = sfc_pkg::DIST_W;
   localparam int TW = sfc_pkg::TOT_W;
   localparam int QB = sfc_pkg::MAG_W;
   localparam int NW = sfc_pkg::NUM_W;

   sfc_pkg::back_state_type state_ff, state_in;
   sfc_pkg::coord_type a_ff [3], a_in [3], b_ff [3], b_in [3], p_ff [3], p_in [3];
   logic [sfc_pkg::PLANE_W-1:0] plane_ff, plane_in;
   logic [sfc_pkg::AXIS_W-1:0]  coord_ff, coord_in;
   logic [sfc_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic          clipped_ff, clipped_in, reject_ff, reject_in;
   logic          o1_ff, o1_in, neg_ff, neg_in;
   logic [DW-1:0] u_ff, u_in;
   logic [TW-1:0] tot_ff, tot_in, rem_ff, rem_in;
   logic [QB-1:0] mag_ff, mag_in, q_ff, q_in;
   logic [NW-1:0] acc_ff, acc_in, sh_ff, sh_in;
   logic          rsp_valid_ff, rsp_valid_in;
   sfc_pkg::rsp_type rsp_ff, rsp_in;

   sfc_pkg::dist_vec_type dist_a, dist_b;
   logic signed [DW-1:0] da, db;
   logic [DW-1:0]        ua, ub;
   logic                 out_a, out_b, out_free;
   logic signed [W:0]    diff;
   logic [NW-1:0]        acc_next;
   logic [TW:0]          r2;
   logic                 ge, round_up;
   logic [QB-1:0]        q_r;
   logic signed [W+1:0]  aw, qw, pw;
   sfc_pkg::coord_type   p_new;

   sfc_dist u_dist_a (.x(a_ff[0]), .y(a_ff[1]), .z(a_ff[2]), .cfg(cfg), .dist_out(dist_a));
   sfc_dist u_dist_b (.x(b_ff[0]), .y(b_ff[1]), .z(b_ff[2]), .cfg(cfg), .dist_out(dist_b));

   // Datapath terms for the current plane and axis
   assign da       = $signed(dist_a[plane_ff]);
   assign db       = $signed(dist_b[plane_ff]);
   assign out_a    = da > 0;
   assign out_b    = db > 0;
   assign ua       = da[DW-1] ? DW'(-da) : DW'(da);
   assign ub       = db[DW-1] ? DW'(-db) : DW'(db);
   assign diff     = (W+1)'(b_ff[coord_ff]) - (W+1)'(a_ff[coord_ff]);
   assign acc_next = acc_ff + (mag_ff[0] ? sh_ff : '0);
   assign r2       = {rem_ff, acc_ff[QB-1]};
   assign ge       = r2 >= {1'b0, tot_ff};
   assign round_up = {rem_ff, 1'b0} >= {1'b0, tot_ff};
   assign q_r      = q_ff + QB'(round_up);
   assign aw       = (W+2)'(a_ff[coord_ff]);
   assign qw       = $signed({1'b0, q_r});
   assign pw       = neg_ff ? aw - qw : aw + qw;
   assign p_new    = pw[W-1:0];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfc_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff       <= a_in;
      b_ff       <= b_in;
      p_ff       <= p_in;
      plane_ff   <= plane_in;
      coord_ff   <= coord_in;
      cnt_ff     <= cnt_in;
      clipped_ff <= clipped_in;
      reject_ff  <= reject_in;
      o1_ff      <= o1_in;
      neg_ff     <= neg_in;
      u_ff       <= u_in;
      tot_ff     <= tot_in;
      rem_ff     <= rem_in;
      mag_ff     <= mag_in;
      q_ff       <= q_in;
      acc_ff     <= acc_in;
      sh_ff      <= sh_in;
      rsp_ff     <= rsp_in;
   end

   // Sequence planes and axes
   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      p_in         = p_ff;
      plane_in     = plane_ff;
      coord_in     = coord_ff;
      cnt_in       = cnt_ff;
      clipped_in   = clipped_ff;
      reject_in    = reject_ff;
      o1_in        = o1_ff;
      neg_in       = neg_ff;
      u_in         = u_ff;
      tot_in       = tot_ff;
      rem_in       = rem_ff;
      mag_in       = mag_ff;
      q_in         = q_ff;
      acc_in       = acc_ff;
      sh_in        = sh_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop_ready    = 1'b0;

      case (state_ff)
         sfc_pkg::BK_IDLE: begin
            if (pop_valid) begin
               if (pop_data.all_in) begin
                  // Pass a segment that is inside everywhere straight out
                  if (out_free) begin
                     pop_ready           = 1'b1;
                     rsp_valid_in        = 1'b1;
                     rsp_in.clip_status  = sfc_pkg::CLIP_ACCEPT;
                     rsp_in.out_start_x  = pop_data.seg.start_x;
                     rsp_in.out_start_y  = pop_data.seg.start_y;
                     rsp_in.out_start_z  = pop_data.seg.start_z;
                     rsp_in.out_end_x    = pop_data.seg.end_x;
                     rsp_in.out_end_y    = pop_data.seg.end_y;
                     rsp_in.out_end_z    = pop_data.seg.end_z;
                  end
               end else begin
                  pop_ready  = 1'b1;
                  a_in[0]    = pop_data.seg.start_x;
                  a_in[1]    = pop_data.seg.start_y;
                  a_in[2]    = pop_data.seg.start_z;
                  b_in[0]    = pop_data.seg.end_x;
                  b_in[1]    = pop_data.seg.end_y;
                  b_in[2]    = pop_data.seg.end_z;
                  plane_in   = '0;
                  clipped_in = 1'b0;
                  reject_in  = 1'b0;
                  state_in   = sfc_pkg::BK_DIST;
               end
            end
         end
         sfc_pkg::BK_DIST: begin
            if (out_a && out_b) begin
               reject_in = 1'b1;
               state_in  = sfc_pkg::BK_DONE;
            end else if (out_a || out_b) begin
               o1_in    = out_a;
               u_in     = ua;
               tot_in   = TW'(ua) + TW'(ub);
               coord_in = '0;
               state_in = sfc_pkg::BK_SETUP;
            end else if (plane_ff == sfc_pkg::PLANE_W'(sfc_pkg::PLANE_N - 1)) begin
               state_in = sfc_pkg::BK_DONE;
            end else begin
               plane_in = plane_ff + 1'b1;
            end
         end
         sfc_pkg::BK_SETUP: begin
            neg_in   = diff[W];
            mag_in   = diff[W] ? QB'(-diff) : QB'(diff);
            acc_in   = '0;
            sh_in    = NW'(u_ff);
            cnt_in   = '0;
            state_in = sfc_pkg::BK_MUL;
         end
         sfc_pkg::BK_MUL: begin
            // Shift-add one multiplier bit per cycle
            acc_in = acc_next;
            sh_in  = sh_ff << 1;
            mag_in = mag_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == sfc_pkg::CNT_W'(QB - 1)) begin
               rem_in   = acc_next[NW-1:QB];
               q_in     = '0;
               cnt_in   = '0;
               state_in = sfc_pkg::BK_DIV;
            end
         end
         sfc_pkg::BK_DIV: begin
            // Restoring divide, one quotient bit per cycle
            rem_in = ge ? TW'(r2 - {1'b0, tot_ff}) : r2[TW-1:0];
            acc_in = acc_ff << 1;
            q_in   = {q_ff[QB-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == sfc_pkg::CNT_W'(QB - 1)) begin
               state_in = sfc_pkg::BK_FIX;
            end
         end
         sfc_pkg::BK_FIX: begin
            p_in[coord_ff] = p_new;
            if (coord_ff == sfc_pkg::AXIS_W'(sfc_pkg::AXIS_N - 1)) begin
               // Replace the outside end, then move to the next plane or finish after the last
               for (int c = 0; c < 2; c++) begin
                  if (o1_ff) begin
                     a_in[c] = p_ff[c];
                  end else begin
                     b_in[c] = p_ff[c];
                  end
               end
               if (o1_ff) begin
                  a_in[2] = p_new;
               end else begin
                  b_in[2] = p_new;
               end
               clipped_in = 1'b1;
               if (plane_ff == sfc_pkg::PLANE_W'(sfc_pkg::PLANE_N - 1)) begin
                  state_in = sfc_pkg::BK_DONE;
               end else begin
                  plane_in = plane_ff + 1'b1;
                  state_in = sfc_pkg::BK_DIST;
               end
            end else begin
               coord_in = coord_ff + 1'b1;
               state_in = sfc_pkg::BK_SETUP;
            end
         end
         sfc_pkg::BK_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (reject_ff) begin
                  rsp_in.clip_status = sfc_pkg::CLIP_REJECT;
                  rsp_in.out_start_x = '0;
                  rsp_in.out_start_y = '0;
                  rsp_in.out_start_z = '0;
                  rsp_in.out_end_x   = '0;
                  rsp_in.out_end_y   = '0;
                  rsp_in.out_end_z   = '0;
               end else begin
                  rsp_in.clip_status = clipped_ff ? sfc_pkg::CLIP_CLIPPED
                                                  : sfc_pkg::CLIP_ACCEPT;
                  rsp_in.out_start_x = a_ff[0];
                  rsp_in.out_start_y = a_ff[1];
                  rsp_in.out_start_z = a_ff[2];
                  rsp_in.out_end_x   = b_ff[0];
                  rsp_in.out_end_y   = b_ff[1];
                  rsp_in.out_end_z   = b_ff[2];
               end
               state_in = sfc_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = sfc_pkg::BK_IDLE;
         end
      endcase
   end

endmodule
